// File: design/ppspd_pkg.sv
// Shared types, constants and unit tables for the pulse-period speedometer.
package ppspd_pkg;

  // Tick period beyond which the wheel counts as stopped
  localparam int TimeoutMs = 30000;

  // Datapath widths
  localparam int PerW  = $clog2(TimeoutMs + 1);
  localparam int NumW  = 22;
  localparam int DenW  = 20;
  localparam int TopW  = 64;
  localparam int BotW  = PerW + DenW + 8;
  localparam int QuotW = 24;
  localparam int DistW = 40;
  localparam int MulAW = 32;
  localparam int MulBW = NumW;
  localparam int ProdW = MulAW + MulBW;

  // Pulse times start one timeout before the counter origin
  localparam logic [31:0] ResetPulseMs = 32'(-TimeoutMs);

  // Configuration register indexes
  localparam logic [7:0] RegCircumference = 8'd0;
  localparam logic [7:0] RegModelScale    = 8'd1;
  localparam logic [7:0] RegCorrection    = 8'd2;
  localparam logic [7:0] RegSpeedUnit     = 8'd3;

  // Configuration reset values
  localparam logic [15:0] CircumferenceRst = 16'd3217;
  localparam logic [9:0]  ModelScaleRst    = 10'd160;
  localparam logic [15:0] CorrectionRst    = 16'd512;

  typedef enum logic [1:0] {
    UNIT_KMH = 2'd0,
    UNIT_MPH = 2'd1,
    UNIT_MPS = 2'd2
  } speed_unit_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PERIOD,
    ST_MUL_K,
    ST_MUL_NLO,
    ST_MUL_NHI,
    ST_MUL_BOT,
    ST_MUL_DIST,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } seq_state_e;

  // Unit multiplier numerator; the unused code behaves as km/h
  function automatic logic [NumW-1:0] unit_num(logic [1:0] unit);
    logic [NumW-1:0] n;
    unique case (unit)
      UNIT_MPH: n = NumW'(2236936);
      UNIT_MPS: n = NumW'(1);
      default:  n = NumW'(3600);
    endcase
    return n;
  endfunction

  // Unit multiplier denominator
  function automatic logic [DenW-1:0] unit_den(logic [1:0] unit);
    logic [DenW-1:0] d;
    unique case (unit)
      UNIT_MPH: d = DenW'(1000000);
      UNIT_MPS: d = DenW'(1);
      default:  d = DenW'(1000);
    endcase
    return d;
  endfunction

endpackage

// File: design/ppspd_div.sv
// Restoring divider with saturation, one quotient bit per cycle.
module ppspd_div
  import ppspd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TopW-1:0]  dividend_i,
  input  logic [BotW-1:0]  divisor_i,
  output logic             done_o,
  output logic [QuotW-1:0] quot_o
);

  localparam int DvsW = BotW + QuotW - 1;
  localparam int CmpW = TopW + BotW;
  localparam int CntW = $clog2(QuotW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [TopW-1:0] rem_q;
  logic [DvsW-1:0] dvs_q;
  logic [QuotW-1:0] quot_q;

  logic            sat;
  logic            ge;
  logic [TopW-1:0] rem_d;

  // Quotient would not fit: dividend / 2^QuotW already reaches the divisor
  assign sat = CmpW'(dividend_i >> QuotW) >= CmpW'(divisor_i);

  // Trial subtract of the shifted divisor
  assign ge    = DvsW'(rem_q) >= dvs_q;
  assign rem_d = ge ? (rem_q - TopW'(dvs_q)) : rem_q;

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= !sat;
      done_q <= sat;
      cnt_q  <= CntW'(QuotW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Remainder, divisor and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dvs_q  <= DvsW'(divisor_i) << (QuotW - 1);
      quot_q <= sat ? '1 : '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      dvs_q  <= dvs_q >> 1;
      quot_q <= {quot_q[QuotW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: design/pulse_period_speedometer.sv
// Pulse-period speedometer and odometer: tick handling, sequencer and output register.
//
// Usage: each request on the input channel (in_valid_i/in_ready_o) is one
// millisecond tick with the sampled wheel sensor level. A rising level counts
// a wheel pulse. Every tick yields exactly one result on the output channel
// (out_valid_o/out_ready_i): speed in the chosen unit (8 fractional bits,
// saturating), distance in whole millimetres, and a flag for a counted pulse.
// Six passes through one shared 32x22 multiplier build the numerator,
// denominator and distance, then a restoring divider takes one quotient bit
// per cycle. A timed out period skips the divider, a saturating quotient ends
// it at once. One tick is in flight at a time and in_ready_o is low
// meanwhile, so a new tick is taken only when the previous one is done. The
// result sits in an output register, so the next tick is accepted while a
// result waits; a stalled receiver holds the sequencer only when a second
// result is ready to load. Configuration writes (cfg_valid_i) are always
// accepted and must happen only while the block is idle.
// Reset: counter at zero, both pulse times one timeout in the past (speed
// reads zero), detector armed, pulse total zero, registers at defaults.
module pulse_period_speedometer
  import ppspd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             sensor_level_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [QuotW-1:0] speed_q8_o,
  output logic [DistW-1:0] distance_mm_o,
  output logic             pulse_seen_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [7:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i
);

  seq_state_e state_q, state_d;

  // Configuration
  logic [15:0] circ_q;
  logic [9:0]  scale_q;
  logic [15:0] corr_q;
  logic [1:0]  unit_q;

  // Tick state
  logic [31:0] now_q;
  logic [31:0] last_q;
  logic [31:0] prev_q;
  logic        armed_q;
  logic [31:0] total_q;
  logic        pulse_q;

  // Datapath
  logic [ProdW-1:0] prod_q;
  logic [9:0]       p2hi_q;
  logic [TopW-1:0]  top_q;
  logic [BotW-1:0]  bot_q;
  logic [PerW-1:0]  per_q;
  logic             tmo_q;
  logic [DistW-1:0] dist_q;
  logic [QuotW-1:0] speed_q;

  // Output register
  logic             out_valid_q;
  logic [QuotW-1:0] out_speed_q;
  logic [DistW-1:0] out_dist_q;
  logic             out_pulse_q;

  logic             in_acc;
  logic             out_load;
  logic             div_start;
  logic             div_done;
  logic [QuotW-1:0] div_quot;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [31:0]      span_a;
  logic [31:0]      span_b;
  logic [31:0]      period;
  logic [31:0]      now_inc;
  logic             pulse_now;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign now_inc     = now_q + 32'd1;
  assign pulse_now   = sensor_level_i && armed_q;

  // Period: longer of the last full interval and the time since the last pulse
  assign span_a = last_q - prev_q;
  assign span_b = now_q - last_q;
  assign period = (span_a > span_b) ? span_a : span_b;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_acc) state_d = ST_PERIOD;
      ST_PERIOD:    state_d = ST_MUL_K;
      ST_MUL_K:     state_d = ST_MUL_NLO;
      ST_MUL_NLO:   state_d = ST_MUL_NHI;
      ST_MUL_NHI:   state_d = ST_MUL_BOT;
      ST_MUL_BOT:   state_d = ST_MUL_DIST;
      ST_MUL_DIST:  state_d = ST_DIV_START;
      ST_DIV_START: state_d = tmo_q ? ST_DONE : ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_done) state_d = ST_DONE;
      ST_DONE:      if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, divider start and multiplier operands
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      ST_IDLE:      in_ready_o = 1'b1;
      ST_PERIOD: begin
        mul_a = MulAW'(circ_q);
        mul_b = MulBW'(scale_q);
      end
      ST_MUL_K: begin
        mul_a = MulAW'(prod_q[25:0]);
        mul_b = MulBW'(corr_q);
      end
      ST_MUL_NLO: begin
        mul_a = prod_q[31:0];
        mul_b = MulBW'(unit_num(unit_q));
      end
      ST_MUL_NHI: begin
        mul_a = MulAW'(p2hi_q);
        mul_b = MulBW'(unit_num(unit_q));
      end
      ST_MUL_BOT: begin
        mul_a = MulAW'(per_q);
        mul_b = MulBW'(unit_den(unit_q));
      end
      ST_MUL_DIST: begin
        mul_a = total_q;
        mul_b = MulBW'(circ_q);
      end
      ST_DIV_START: div_start = !tmo_q;
      ST_DIV_WAIT:  ;
      ST_DONE:      out_load = !out_valid_q || out_ready_i;
      default:      ;
    endcase
  end

  // Control registers, configuration and tick state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      circ_q      <= CircumferenceRst;
      scale_q     <= ModelScaleRst;
      corr_q      <= CorrectionRst;
      unit_q      <= UNIT_KMH;
      now_q       <= '0;
      last_q      <= ResetPulseMs;
      prev_q      <= ResetPulseMs;
      armed_q     <= 1'b1;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // take configuration writes; unknown indexes are dropped
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegCircumference: circ_q  <= cfg_data_i;
          RegModelScale:    scale_q <= cfg_data_i[9:0];
          RegCorrection:    corr_q  <= cfg_data_i;
          RegSpeedUnit:     unit_q  <= cfg_data_i[1:0];
          default:          ;
        endcase
      end
      // advance the clock and detect a rising level
      if (in_acc) begin
        now_q <= now_inc;
        if (sensor_level_i) begin
          if (armed_q) begin
            armed_q <= 1'b0;
            prev_q  <= last_q;
            last_q  <= now_inc;
            total_q <= total_q + 32'd1;
          end
        end else begin
          armed_q <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
    if (in_acc) begin
      pulse_q <= pulse_now;
    end
    unique case (state_q)
      ST_PERIOD: begin
        tmo_q <= period > 32'(TimeoutMs);
        per_q <= (period == '0) ? PerW'(1) : period[PerW-1:0];
      end
      ST_MUL_NLO:   p2hi_q <= prod_q[41:32];
      ST_MUL_NHI:   top_q  <= TopW'(prod_q);
      ST_MUL_BOT:   top_q  <= top_q + {prod_q[31:0], 32'd0};
      ST_MUL_DIST:  bot_q  <= {prod_q[BotW-9:0], 8'd0};
      ST_DIV_START: begin
        dist_q <= prod_q[DistW+7:8];
        if (tmo_q) speed_q <= '0;
      end
      ST_DIV_WAIT:  if (div_done) speed_q <= div_quot;
      default:      ;
    endcase
    // hold the result for the receiver
    if (out_load) begin
      out_speed_q <= speed_q;
      out_dist_q  <= dist_q;
      out_pulse_q <= pulse_q;
    end
  end

  ppspd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (top_q),
    .divisor_i  (bot_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign out_valid_o   = out_valid_q;
  assign speed_q8_o    = out_speed_q;
  assign distance_mm_o = out_dist_q;
  assign pulse_seen_o  = out_pulse_q;

`ifndef SYNTHESIS
  // A divider result arrives only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

  // The pulse total grows by one exactly on a counted pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (total_q == $past(total_q) + 32'($past(pulse_now))))
    else $error("pulse total out of step with pulse detection");

  // A timed-out period always loads a zero speed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && tmo_q) |-> (speed_q == '0))
    else $error("non-zero speed after timeout");

  // A counted pulse leaves the detector disarmed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pulse_now) |=> !armed_q)
    else $error("detector still armed after a pulse");
`endif

endmodule
